@@ rtl/core/lrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg
// Widths, latencies and register codes shared by the line clipper modules.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int COORD_BITS = 16;
    localparam int COEF_W     = COORD_BITS + 1;
    localparam int CONST_W    = 2 * COORD_BITS + 2;
    localparam int PROD_W     = COEF_W + COORD_BITS;
    localparam int NUM_W      = CONST_W + 2;
    localparam int QUO_W      = COORD_BITS;
    localparam int DIV_LAT    = QUO_W + 2;
    localparam int PIPE_DEPTH = DIV_LAT + 4;
    localparam int NUM_LANES  = 4;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_TOP    = 2'd2,
        REG_BOTTOM = 2'd3
    } cfg_reg_t;

endpackage

@@ rtl/core/lrc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Flags a quotient whose magnitude does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module lrc_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic signed [lrc_pkg::NUM_W-1:0]     num,
    input  logic        [lrc_pkg::COEF_W-1:0]    den,
    input  logic                                 neg,
    input  logic                                 ok_in,
    output logic signed [lrc_pkg::QUO_W:0]       quo,
    output logic                                 ok_out
);
    import lrc_pkg::*;

    logic [NUM_W-1:0]  mag_reg;
    logic [COEF_W-1:0] den_a_reg;
    logic              neg_a_reg;
    logic              ok_a_reg;

    logic [NUM_W-1:0]  rem_reg  [0:QUO_W];
    logic [QUO_W-1:0]  q_reg    [0:QUO_W];
    logic [COEF_W-1:0] dv_reg   [0:QUO_W];
    logic              neg_reg  [0:QUO_W];
    logic              ok_reg   [0:QUO_W];

    logic [NUM_W-1:0]  rem_next [1:QUO_W];
    logic [QUO_W-1:0]  q_next   [1:QUO_W];
    logic [NUM_W-1:0]  lim;

    assign lim = {{(NUM_W-COEF_W){1'b0}}, den_a_reg} << QUO_W;

    always_comb
    begin
        logic [NUM_W-1:0] dsh;
        dsh = '0;
        for (int k = 0; k < QUO_W; k++)
        begin
            dsh = {{(NUM_W-COEF_W){1'b0}}, dv_reg[k]} << (QUO_W - 1 - k);
            if (rem_reg[k] >= dsh)
            begin
                rem_next[k+1] = rem_reg[k] - dsh;
                q_next[k+1]   = q_reg[k] | (QUO_W'(1) << (QUO_W - 1 - k));
            end
            else
            begin
                rem_next[k+1] = rem_reg[k];
                q_next[k+1]   = q_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_a_reg <= 1'b0;
            for (int k = 0; k <= QUO_W; k++)
            begin
                ok_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            ok_a_reg <= ok_in;
            ok_reg[0] <= ok_a_reg && (mag_reg < lim);
            for (int k = 0; k < QUO_W; k++)
            begin
                ok_reg[k+1] <= ok_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            den_a_reg  <= den;
            neg_a_reg  <= neg;
            rem_reg[0] <= mag_reg;
            q_reg[0]   <= '0;
            dv_reg[0]  <= den_a_reg;
            neg_reg[0] <= neg_a_reg;
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k+1] <= rem_next[k+1];
                q_reg[k+1]   <= q_next[k+1];
                dv_reg[k+1]  <= dv_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign quo    = neg_reg[QUO_W] ? -$signed({1'b0, q_reg[QUO_W]})
                                   : $signed({1'b0, q_reg[QUO_W]});
    assign ok_out = ok_reg[QUO_W];

endmodule

@@ rtl/core/line_rect_clipper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rect_clipper
// Clips an infinite line against an axis-aligned rectangle.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready): one line per beat, either as
// coefficients a*x + b*y + c = 0 (cmd 0) or as two points (cmd 1).
// Output channel (out_valid / out_ready): one result beat per line, with the
// first two intersections that lie inside the rectangle, or hit low.
// Configuration channel (cfg_valid / cfg_ready): cfg_index selects the left,
// right, top or bottom edge and cfg_data is written; cfg_ready is always high.
// Write edges only while no line is in flight.
// The four dividers, which resolve one quotient bit a stage, set the depth.
// Throughput is one line per cycle while the receiver does not stall.
// Reset empties the pipeline and loads the default rectangle. When the
// receiver stalls, the whole pipeline holds and in_ready drops while a
// result waits; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module line_rect_clipper (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [1:0]                              cfg_index,
    input  logic signed [lrc_pkg::COORD_BITS-1:0]   cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    cmd,
    input  logic signed [lrc_pkg::COEF_W-1:0]       coef_a,
    input  logic signed [lrc_pkg::COEF_W-1:0]       coef_b,
    input  logic signed [lrc_pkg::CONST_W-1:0]      coef_c,
    input  logic signed [lrc_pkg::COORD_BITS-1:0]   point_x1,
    input  logic signed [lrc_pkg::COORD_BITS-1:0]   point_y1,
    input  logic signed [lrc_pkg::COORD_BITS-1:0]   point_x2,
    input  logic signed [lrc_pkg::COORD_BITS-1:0]   point_y2,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    hit,
    output logic signed [lrc_pkg::COORD_BITS-1:0]   first_x,
    output logic signed [lrc_pkg::COORD_BITS-1:0]   first_y,
    output logic signed [lrc_pkg::COORD_BITS-1:0]   second_x,
    output logic signed [lrc_pkg::COORD_BITS-1:0]   second_y
);
    import lrc_pkg::*;

    logic signed [COORD_BITS-1:0] left_reg, right_reg, top_reg, bottom_reg;
    logic                         vld_reg [0:PIPE_DEPTH-1];
    logic                         out_valid_reg;
    logic                         en;

    // stage 1
    logic signed [COEF_W-1:0]  dx, dy;
    logic signed [COEF_W-1:0]  a1_reg, b1_reg;
    logic signed [CONST_W-1:0] c1_reg;
    logic signed [PROD_W-1:0]  p1_reg, p2_reg;
    logic                      cmd1_reg, nul1_reg;

    // stage 2
    logic signed [CONST_W-1:0] c2_reg;
    logic signed [COEF_W-1:0]  a2_reg, b2_reg;
    logic signed [PROD_W-1:0]  ae_l_reg, ae_r_reg, be_t_reg, be_b_reg;
    logic                      nul2_reg;

    // stage 3
    logic signed [NUM_W-1:0]   num_reg [0:NUM_LANES-1];
    logic [COEF_W-1:0]         den_reg [0:NUM_LANES-1];
    logic                      neg_reg [0:NUM_LANES-1];
    logic                      ok_reg  [0:NUM_LANES-1];

    logic signed [NUM_W-1:0]   c2x;
    logic [COEF_W-1:0]         abs_a, abs_b;

    logic signed [QUO_W:0]     quo     [0:NUM_LANES-1];
    logic                      quo_ok  [0:NUM_LANES-1];

    // inside stage
    logic [NUM_LANES-1:0]         kept_reg;
    logic signed [COORD_BITS-1:0] px_reg [0:NUM_LANES-1];
    logic signed [COORD_BITS-1:0] py_reg [0:NUM_LANES-1];
    logic signed [COORD_BITS-1:0] px_next [0:NUM_LANES-1];
    logic signed [COORD_BITS-1:0] py_next [0:NUM_LANES-1];
    logic [NUM_LANES-1:0]         kept_next;

    // output stage
    logic                         hit_reg, hit_next;
    logic signed [COORD_BITS-1:0] fx_reg, fy_reg, sx_reg, sy_reg;
    logic signed [COORD_BITS-1:0] fx_next, fy_next, sx_next, sy_next;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= 16'sh7fff;
            top_reg    <= 16'sh7fff;
            bottom_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_TOP:    top_reg    <= cfg_data;
                REG_BOTTOM: bottom_reg <= cfg_data;
                default:    left_reg   <= left_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    assign dx = COEF_W'(point_x1) - COEF_W'(point_x2);
    assign dy = COEF_W'(point_y1) - COEF_W'(point_y2);

    // line set-up: coefficients and the two products of the point form
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= cmd;
            nul1_reg <= cmd && (dx == '0) && (dy == '0);
            a1_reg   <= cmd ? dy : coef_a;
            b1_reg   <= cmd ? -dx : coef_b;
            c1_reg   <= coef_c;
            p1_reg   <= point_y1 * dx;
            p2_reg   <= point_x1 * dy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg   <= cmd1_reg ? (CONST_W'(p1_reg) - CONST_W'(p2_reg)) : c1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            nul2_reg <= nul1_reg;
            ae_l_reg <= a1_reg * left_reg;
            ae_r_reg <= a1_reg * right_reg;
            be_t_reg <= b1_reg * top_reg;
            be_b_reg <= b1_reg * bottom_reg;
        end
    end

    assign c2x   = NUM_W'(c2_reg);
    assign abs_a = a2_reg[COEF_W-1] ? COEF_W'(-a2_reg) : COEF_W'(a2_reg);
    assign abs_b = b2_reg[COEF_W-1] ? COEF_W'(-b2_reg) : COEF_W'(b2_reg);

    // numerators: vertical edges divide by b, horizontal ones by -a
    always_ff @(posedge clk)
    begin
        logic signed [NUM_W-1:0] nl, nr, nt, nb;
        nl = -c2x - NUM_W'(ae_l_reg);
        nr = -c2x - NUM_W'(ae_r_reg);
        nt = NUM_W'(be_t_reg) + c2x;
        nb = NUM_W'(be_b_reg) + c2x;
        if (en)
        begin
            num_reg[0] <= nl;
            num_reg[1] <= nr;
            num_reg[2] <= nt;
            num_reg[3] <= nb;
            den_reg[0] <= abs_b;
            den_reg[1] <= abs_b;
            den_reg[2] <= abs_a;
            den_reg[3] <= abs_a;
            neg_reg[0] <= nl[NUM_W-1] ^ b2_reg[COEF_W-1];
            neg_reg[1] <= nr[NUM_W-1] ^ b2_reg[COEF_W-1];
            neg_reg[2] <= nt[NUM_W-1] ^ (!a2_reg[COEF_W-1] && (a2_reg != '0));
            neg_reg[3] <= nb[NUM_W-1] ^ (!a2_reg[COEF_W-1] && (a2_reg != '0));
            ok_reg[0]  <= !nul2_reg && (b2_reg != '0);
            ok_reg[1]  <= !nul2_reg && (b2_reg != '0);
            ok_reg[2]  <= !nul2_reg && (a2_reg != '0);
            ok_reg[3]  <= !nul2_reg && (a2_reg != '0);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        lrc_div u_div (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .num    (num_reg[g]),
            .den    (den_reg[g]),
            .neg    (neg_reg[g]),
            .ok_in  (ok_reg[g]),
            .quo    (quo[g]),
            .ok_out (quo_ok[g])
        );
    end

    always_comb
    begin
        px_next[0] = left_reg;
        py_next[0] = quo[0][COORD_BITS-1:0];
        px_next[1] = right_reg;
        py_next[1] = quo[1][COORD_BITS-1:0];
        px_next[2] = quo[2][COORD_BITS-1:0];
        py_next[2] = top_reg;
        px_next[3] = quo[3][COORD_BITS-1:0];
        py_next[3] = bottom_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            // quotient must fit the coordinate range
            kept_next[i] = quo_ok[i] && (quo[i][QUO_W] == quo[i][QUO_W-1]) &&
                           (px_next[i] >= left_reg) && (px_next[i] <= right_reg) &&
                           (py_next[i] >= bottom_reg) && (py_next[i] <= top_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kept_reg <= kept_next;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                px_reg[i] <= px_next[i];
                py_reg[i] <= py_next[i];
            end
        end
    end

    // first two kept points in edge order, the first repeated if alone
    always_comb
    begin
        logic [2:0] n;
        n        = '0;
        fx_next  = '0;
        fy_next  = '0;
        sx_next  = '0;
        sy_next  = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (kept_reg[i])
            begin
                if (n == 3'd0)
                begin
                    fx_next = px_reg[i];
                    fy_next = py_reg[i];
                    sx_next = px_reg[i];
                    sy_next = py_reg[i];
                end
                else if (n == 3'd1)
                begin
                    sx_next = px_reg[i];
                    sy_next = py_reg[i];
                end
                n = n + 3'd1;
            end
        end
        hit_next = (kept_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign first_x   = fx_reg;
    assign first_y   = fy_reg;
    assign second_x  = sx_reg;
    assign second_y  = sy_reg;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line rectangle clipper: directed and random
// lines under several rectangles and idling phases, each result compared
// against an in-bench prediction of the clipped end points.
// ----------------------------------------------------------------------------
module tb_top;
    import lrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic                 hit;
        logic [COORD_BITS-1:0] fx;
        logic [COORD_BITS-1:0] fy;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
    } clip_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic signed [COORD_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = 1'b0;
    logic signed [COEF_W-1:0] coef_a = '0;
    logic signed [COEF_W-1:0] coef_b = '0;
    logic signed [CONST_W-1:0] coef_c = '0;
    logic signed [COORD_BITS-1:0] point_x1 = '0;
    logic signed [COORD_BITS-1:0] point_y1 = '0;
    logic signed [COORD_BITS-1:0] point_x2 = '0;
    logic signed [COORD_BITS-1:0] point_y2 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;

    longint rect_l, rect_r, rect_t, rect_b;
    clip_t expected_clips[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit failed = 1'b0;
    int quiet_cycles = 0;

    line_rect_clipper u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit coord_ok(longint v);
        return v >= -(64'sd1 <<< (COORD_BITS - 1)) && v < (64'sd1 <<< (COORD_BITS - 1));
    endfunction

    function automatic bit in_rect(longint x, longint y);
        return coord_ok(x) && coord_ok(y) && x >= rect_l && x <= rect_r
               && y >= rect_b && y <= rect_t;
    endfunction

    // intersections with left, right, top, bottom in that order
    function automatic clip_t clip_line(bit c_cmd, longint a_in, longint b_in, longint c_in,
                                        longint x1, longint y1, longint x2, longint y2);
        longint a, b, c, x, y;
        longint kx[4], ky[4];
        longint edges[4];
        int n;
        clip_t r;
        n = 0;
        r = '0;
        if (!c_cmd)
        begin
            a = a_in; b = b_in; c = c_in;
        end
        else
        begin
            a = y1 - y2; b = x2 - x1; c = y1 * (x1 - x2) - x1 * (y1 - y2);
            if (x1 == x2 && y1 == y2)
                return r;
        end
        edges[0] = rect_l; edges[1] = rect_r; edges[2] = rect_t; edges[3] = rect_b;
        for (int e = 0; e < 4; e++)
        begin
            if (e < 2)
            begin
                if (b == 0)
                    continue;
                x = edges[e];
                y = (-c - a * edges[e]) / b;
            end
            else
            begin
                if (a == 0)
                    continue;
                x = (b * edges[e] + c) / (-a);
                y = edges[e];
            end
            if (in_rect(x, y))
            begin
                kx[n] = x; ky[n] = y; n++;
            end
        end
        if (n > 0)
        begin
            r.hit = 1'b1;
            r.fx = kx[0][COORD_BITS-1:0];
            r.fy = ky[0][COORD_BITS-1:0];
            r.sx = kx[n > 1][COORD_BITS-1:0];
            r.sy = ky[n > 1][COORD_BITS-1:0];
        end
        return r;
    endfunction

    // valid stays up between back-to-back beats and drops only while idling
    task automatic send_line(bit c_cmd, longint a, longint b, longint c,
                             longint x1, longint y1, longint x2, longint y2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        expected_clips.push_back(clip_line(c_cmd, a, b, c, x1, y1, x2, y2));
        in_valid <= 1'b1;
        cmd      <= c_cmd;
        coef_a   <= a[COEF_W-1:0];
        coef_b   <= b[COEF_W-1:0];
        coef_c   <= c[CONST_W-1:0];
        point_x1 <= x1[COORD_BITS-1:0];
        point_y1 <= y1[COORD_BITS-1:0];
        point_x2 <= x2[COORD_BITS-1:0];
        point_y2 <= y2[COORD_BITS-1:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_edge(cfg_reg_t idx, longint v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[COORD_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LEFT:   rect_l = v;
            REG_RIGHT:  rect_r = v;
            REG_TOP:    rect_t = v;
            REG_BOTTOM: rect_b = v;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_clips.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic set_rect(longint l, longint r, longint t, longint b);
        drain();
        write_edge(REG_LEFT, l);
        write_edge(REG_RIGHT, r);
        write_edge(REG_TOP, t);
        write_edge(REG_BOTTOM, b);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return $signed($urandom_range(64)) - 32;
            default: return $signed($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic longint rand_coef();
        case ($urandom_range(5))
            0: return 0;
            1: return -65536;
            2: return 65535;
            default: return $signed($urandom_range(131071)) - 65536;
        endcase
    endfunction

    function automatic longint rand_const();
        longint v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(4))
            0: return -(64'sd1 <<< 33);
            1: return (64'sd1 <<< 33) - 1;
            2: return (v <<< 30) >>> 30;
            default: return (v <<< 44) >>> 44;
        endcase
    endfunction

    task automatic send_random_line();
        longint x1, y1;
        if ($urandom_range(1))
        begin
            x1 = rand_coord();
            y1 = rand_coord();
            // occasionally a degenerate point pair
            if ($urandom_range(15) == 0)
                send_line(1'b1, 0, 0, 0, x1, y1, x1, y1);
            else
                send_line(1'b1, 0, 0, 0, x1, y1, rand_coord(), rand_coord());
        end
        else
            send_line(1'b0, rand_coef(), rand_coef(), rand_const(), 0, 0, 0, 0);
    endtask

    task automatic test_directed();
        send_line(1'b1, 0, 0, 0, 0, 0, 32767, 32767);        // diagonal through corners
        send_line(1'b1, 0, 0, 0, 100, 100, 100, 100);        // equal points
        send_line(1'b1, 0, 0, 0, 10, -5, 10, 20);            // vertical line
        send_line(1'b1, 0, 0, 0, -5, 50, 20, 50);            // horizontal line
        send_line(1'b1, 0, 0, 0, -32768, -32768, 32767, 32767);
        send_line(1'b1, 0, 0, 0, 32767, -32768, -32768, 32767);
        send_line(1'b1, 0, 0, 0, -32768, 0, 32767, 0);       // on bottom edge
        send_line(1'b0, 0, 0, 0, 0, 0, 0, 0);                // all zero
        send_line(1'b0, 16, 0, -256, 0, 0, 0, 0);            // x = 16
        send_line(1'b0, 0, 16, -512, 0, 0, 0, 0);            // y = 32
        send_line(1'b0, -65536, 65535, 0, 0, 0, 0, 0);
        send_line(1'b0, 65535, -65536, -(64'sd1 <<< 33), 0, 0, 0, 0);
        send_line(1'b0, -65536, -65536, (64'sd1 <<< 33) - 1, 0, 0, 0, 0);
        send_line(1'b0, 1, 1, -100, 0, 0, 0, 0);             // huge quotients
        send_line(1'b0, 16, -16, 0, 0, 0, 0, 0);
        send_line(1'b1, 0, 0, 0, 0, 32767, 32767, 0);
    endtask

    task automatic test_random(int count);
        repeat (count) send_random_line();
    endtask

    // long receiver hold-off while lines keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(60);
        join
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        clip_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {hit, first_x, first_y, second_x, second_y};
            if (expected_clips.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_clips.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                    failed = 1'b1;
                end
                if (got.fx !== want.fx || got.fy !== want.fy)
                begin
                    $display("%0t: first expected (%0d,%0d) actual (%0d,%0d)", $time,
                             $signed(want.fx), $signed(want.fy),
                             $signed(got.fx), $signed(got.fy));
                    failed = 1'b1;
                end
                if (got.sx !== want.sx || got.sy !== want.sy)
                begin
                    $display("%0t: second expected (%0d,%0d) actual (%0d,%0d)", $time,
                             $signed(want.sx), $signed(want.sy),
                             $signed(got.sx), $signed(got.sy));
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rect_l = 0; rect_r = 32767; rect_t = 32767; rect_b = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_rect(-32768, 32767, 32767, -32768);
        test_directed();
        set_rect(-800, 800, 600, -600);
        test_random(400);
        send_idle_pct = 68;
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        set_rect(-40, 40, 30, -30);
        test_random(300);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        set_rect(-16000, 12000, 9000, -20000);
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        set_rect(10, 10, 5, 5);                      // single point
        test_random(150);
        set_rect(100, -100, 50, 60);                 // empty rectangle
        test_random(100);
        set_rect(-32768, 32767, 32767, -32768);
        recv_stall_pct = 20;
        test_random(250);
        drain();

        if (failed)
            $display("Mismatches found");
        else
            $display("No mismatches found");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/lrc_pkg.sv
rtl/core/lrc_div.sv
rtl/core/line_rect_clipper.sv
tb/sv/tb_top.sv
